@@ sv/xy_lattice_metropolis_update_defines.svh @@
// Assertion macros used by the updater RTL.
`ifndef XY_LATTICE_METROPOLIS_UPDATE_DEFINES_SVH
`define XY_LATTICE_METROPOLIS_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XYLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XYLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/xylm_pkg.sv @@
package xylm_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_TRIAL = 2'd1;

  localparam int unsigned DH_W   = 19;
  localparam int unsigned TEMP_W = 16;
  localparam int unsigned DRAW_W = 16;
  localparam int unsigned MUL_W  = 31;
  localparam int unsigned PROD_W = 62;
  localparam int unsigned NUM_W  = 42;

  localparam logic [MUL_W-1:0] COS_C5 = 31'd27061;
  localparam logic [31:0] COS_COEF [5] = '{32'd987049, 32'd22401992, 32'd272375566,
                                           32'd1324675879, 32'd1073741824};

  localparam logic [NUM_W-1:0] EXP_LIMIT = 42'd12884901888;
  localparam logic [33:0]      LN2_Q30   = 34'd744261118;
  localparam logic [31:0]      Q30_ONE   = 32'd1073741824;
  localparam logic [3:0]       TERM_LAST = 4'd12;

  // Reciprocals of the term index n, ceil(2^sh / n), exact for dividends below 2^30.
  localparam logic [MUL_W-1:0] RECIP_M [13] = '{
    31'd0,          31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
    31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824, 31'd1908874354,
    31'd1717986919, 31'd1561806290, 31'd1431655766};
  localparam logic [5:0] RECIP_SH [13] = '{
    6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34,
    6'd34};

endpackage

@@ sv/xylm_ram.sv @@
module xylm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/xy_lattice_metropolis_update.sv @@
// Metropolis updater for an XY spin lattice held in one on-chip RAM. One word is
// processed at a time; the next word is taken in the cycle after the result
// reaches the output register. A load word writes the RAM as it is accepted and
// goes straight to the output stage; a read word first reads its site. A trial word
// reads the site and its four wrapped neighbors at one RAM access per cycle, runs
// eight cosines through one shared 31x31 multiplier and spends the S_DH state on
// the sign test, where a trial is decided by sign or by a zero temperature.
// Otherwise a bit-serial divider forms dH/T, a subtract loop removes multiples of
// ln 2, and twelve Taylor terms each take one multiply and one multiply by the
// reciprocal of the term index; an out-of-range exponent rejects the trial after
// the divider. A stalled output holds both the result and the input.
`include "xy_lattice_metropolis_update_defines.svh"

module xy_lattice_metropolis_update #(
  parameter int LATTICE_BITS = 6,
  parameter int ANGLE_BITS   = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [xylm_pkg::TEMP_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  xylm_pkg::kind_t                in_kind,
  input  logic [LATTICE_BITS-1:0]        in_site_x,
  input  logic [LATTICE_BITS-1:0]        in_site_y,
  input  logic [ANGLE_BITS-1:0]          in_angle_value,
  input  logic [xylm_pkg::DRAW_W-1:0]    in_uniform_draw,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic [ANGLE_BITS-1:0]          out_site_angle,
  output logic signed [xylm_pkg::DH_W-1:0] out_delta_energy
);

  import xylm_pkg::*;

  localparam int ADDR_W = 2 * LATTICE_BITS;
  localparam int QTR_W  = ANGLE_BITS - 2;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_COS_SQ, S_COS_T2, S_COS_MUL, S_COS_ACC, S_COS_END, S_DH,
    S_DIV, S_DIVDONE, S_KRED, S_TMUL, S_TDIV, S_CMP, S_WB, S_FIN
  } state_t;

  state_t                    state_r;
  logic [TEMP_W-1:0]         temp_r;
  kind_t                     kind_r;
  logic [LATTICE_BITS-1:0]   x_r, y_r;
  logic [ANGLE_BITS-1:0]     ang_r, old_r;
  logic [ANGLE_BITS-1:0]     nb_r [4];
  logic [DRAW_W-1:0]         draw_r;
  logic [2:0]                fetch_cnt_r;
  logic [2:0]                cos_idx_r;
  logic [2:0]                h_r;
  logic [MUL_W-1:0]          t2_r;
  logic signed [33:0]        p_r;
  logic [PROD_W-1:0]         prod_r;
  logic signed [DH_W-1:0]    sum_r;
  logic                      acc_r;
  logic [NUM_W-1:0]          div_num_r;
  logic [TEMP_W-1:0]         div_den_r;
  logic [TEMP_W-1:0]         div_rem_r;
  logic [5:0]                div_cnt_r;
  logic                      div_term_r;
  logic [33:0]               xr_r;
  logic [4:0]                k_r;
  logic [MUL_W-1:0]          term_r;
  logic [31:0]               esum_r;
  logic [3:0]                n_r;
  logic                      out_valid_r;
  logic                      out_acc_r;
  logic [ANGLE_BITS-1:0]     out_angle_r;
  logic signed [DH_W-1:0]    out_dh_r;

  logic [ADDR_W-1:0]         raddr;
  logic [ADDR_W-1:0]         site_addr;
  logic [ANGLE_BITS-1:0]     rdata;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ANGLE_BITS-1:0]     ram_wdata;
  logic                      in_fire;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic [ANGLE_BITS-1:0]     diff;
  logic [1:0]                quad;
  logic [ANGLE_BITS-2:0]     x_fold;
  logic [MUL_W-1:0]          t_val;
  logic [16:0]               q_round;
  logic [14:0]               q_val;
  logic signed [15:0]        cos_v;
  logic signed [DH_W-1:0]    sum_nxt;
  logic signed [33:0]        p_nxt;
  logic [TEMP_W:0]           rem_sh;
  logic                      div_ge;
  logic [MUL_W-1:0]          term_q;
  logic [31:0]               esum_nxt;
  logic [31:0]               exp_val;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign site_addr = {x_r, y_r};

  always_comb begin
    unique case (fetch_cnt_r)
      3'd1:    raddr = {x_r - 1'b1, y_r};
      3'd2:    raddr = {x_r + 1'b1, y_r};
      3'd3:    raddr = {x_r, y_r + 1'b1};
      3'd4:    raddr = {x_r, y_r - 1'b1};
      default: raddr = site_addr;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = site_addr;
    ram_wdata = ang_r;
    if (in_fire && in_kind == KIND_LOAD) begin
      ram_we    = 1'b1;
      ram_waddr = {in_site_x, in_site_y};
      ram_wdata = in_angle_value;
    end else if (state_r == S_WB && acc_r) begin
      ram_we = 1'b1;
    end
  end

  xylm_ram #(
    .WIDTH (ANGLE_BITS),
    .DEPTH (1 << ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    diff    = (cos_idx_r[0] ? ang_r : old_r) - nb_r[cos_idx_r[2:1]];
    quad    = diff[ANGLE_BITS-1 -: 2];
    x_fold  = quad[0] ? ((ANGLE_BITS-1)'(1) << QTR_W) - (ANGLE_BITS-1)'(diff[QTR_W-1:0])
                      : (ANGLE_BITS-1)'(diff[QTR_W-1:0]);
    t_val   = {x_fold, {(32 - ANGLE_BITS){1'b0}}};
    q_round = p_r[33] ? 17'd0 : 17'((p_r + 34'sd32768) >>> 16);
    q_val   = (q_round > 17'd16384) ? 15'd16384 : q_round[14:0];
    cos_v   = (quad == 2'd1 || quad == 2'd2) ? -$signed({1'b0, q_val}) : $signed({1'b0, q_val});
    sum_nxt = cos_idx_r[0] ? sum_r - {{3{cos_v[15]}}, cos_v}
                           : sum_r + {{3{cos_v[15]}}, cos_v};
    p_nxt   = $signed({2'b00, COS_COEF[h_r]}) - $signed({2'b00, prod_r[61:30]});
  end

  always_comb begin
    mul_a = t_val;
    mul_b = t_val;
    unique case (state_r)
      S_COS_MUL: begin
        mul_a = p_r[MUL_W-1:0];
        mul_b = t2_r;
      end
      S_TMUL: begin
        mul_a = term_r;
        mul_b = {1'b0, xr_r[29:0]};
      end
      S_TDIV: begin
        mul_a = prod_r[MUL_W+29:30];
        mul_b = RECIP_M[n_r];
      end
      default: begin
        mul_a = t_val;
        mul_b = t_val;
      end
    endcase
  end

  always_comb begin
    rem_sh   = {div_rem_r, div_num_r[NUM_W-1]};
    div_ge   = rem_sh >= {1'b0, div_den_r};
    term_q   = MUL_W'(prod_r >> RECIP_SH[n_r]);
    esum_nxt = n_r[0] ? esum_r - {1'b0, term_q} : esum_r + {1'b0, term_q};
    exp_val  = esum_r >> k_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      temp_r      <= TEMP_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        temp_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r      <= in_kind;
            x_r         <= in_site_x;
            y_r         <= in_site_y;
            ang_r       <= in_angle_value;
            draw_r      <= in_uniform_draw;
            sum_r       <= '0;
            fetch_cnt_r <= '0;
            acc_r       <= 1'b1;
            old_r       <= in_angle_value;
            state_r     <= (in_kind == KIND_LOAD) ? S_FIN : S_FETCH;
          end
        end
        S_FETCH: begin
          fetch_cnt_r <= fetch_cnt_r + 3'd1;
          if (fetch_cnt_r == 3'd1) begin
            old_r <= rdata;
          end else if (fetch_cnt_r != 3'd0) begin
            nb_r[2'(fetch_cnt_r - 3'd2)] <= rdata;
          end
          if (fetch_cnt_r == 3'd1 && kind_r != KIND_TRIAL) begin
            acc_r   <= 1'b0;
            state_r <= S_FIN;
          end else if (fetch_cnt_r == 3'd5) begin
            cos_idx_r <= '0;
            state_r   <= S_COS_SQ;
          end
        end
        S_COS_SQ: state_r <= S_COS_T2;
        S_COS_T2: begin
          t2_r    <= prod_r[60:30];
          p_r     <= {3'b000, COS_C5};
          h_r     <= '0;
          state_r <= S_COS_MUL;
        end
        S_COS_MUL: state_r <= S_COS_ACC;
        S_COS_ACC: begin
          p_r <= p_nxt;
          if (h_r == 3'd4) begin
            state_r <= S_COS_END;
          end else begin
            h_r     <= h_r + 3'd1;
            state_r <= S_COS_MUL;
          end
        end
        S_COS_END: begin
          sum_r     <= sum_nxt;
          cos_idx_r <= cos_idx_r + 3'd1;
          state_r   <= (cos_idx_r == 3'd7) ? S_DH : S_COS_SQ;
        end
        S_DH: begin
          if (sum_r <= 0) begin
            acc_r   <= 1'b1;
            state_r <= S_WB;
          end else if (temp_r == '0) begin
            acc_r   <= 1'b0;
            state_r <= S_WB;
          end else begin
            div_num_r  <= NUM_W'(sum_r[17:0]) << 24;
            div_den_r  <= temp_r;
            div_rem_r  <= '0;
            div_cnt_r  <= '0;
            div_term_r <= 1'b0;
            state_r    <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem_r <= div_ge ? TEMP_W'(rem_sh - {1'b0, div_den_r}) : rem_sh[TEMP_W-1:0];
          div_num_r <= {div_num_r[NUM_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'(NUM_W - 1)) begin
            state_r <= S_DIVDONE;
          end
        end
        S_DIVDONE: begin
          if (!div_term_r) begin
            if (div_num_r >= EXP_LIMIT) begin
              acc_r   <= 1'b0;
              state_r <= S_WB;
            end else begin
              xr_r    <= div_num_r[33:0];
              k_r     <= '0;
              state_r <= S_KRED;
            end
          end else begin
            term_r  <= term_q;
            esum_r  <= esum_nxt;
            n_r     <= n_r + 4'd1;
            state_r <= (n_r == TERM_LAST) ? S_CMP : S_TMUL;
          end
        end
        S_KRED: begin
          if (xr_r >= LN2_Q30) begin
            xr_r <= xr_r - LN2_Q30;
            k_r  <= k_r + 5'd1;
          end else begin
            term_r  <= Q30_ONE[MUL_W-1:0];
            esum_r  <= Q30_ONE;
            n_r     <= 4'd1;
            state_r <= S_TMUL;
          end
        end
        S_TMUL: state_r <= S_TDIV;
        S_TDIV: begin
          div_term_r <= 1'b1;
          state_r    <= S_DIVDONE;
        end
        S_CMP: begin
          acc_r   <= {2'b00, draw_r, 14'd0} < exp_val;
          state_r <= S_WB;
        end
        S_WB: begin
          if (acc_r) begin
            old_r <= ang_r;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_acc_r   <= acc_r;
            out_angle_r <= old_r;
            out_dh_r    <= sum_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_site_angle   = out_angle_r;
  assign out_delta_energy = out_dh_r;

  `XYLM_ASSERT_SAME(a_ram_write_src, ram_we,
    (in_fire && in_kind == KIND_LOAD) || (state_r == S_WB && acc_r),
    "Lattice RAM written outside a load or an accepted trial.")
  `XYLM_ASSERT_SAME(a_dh_range, out_valid_r,
    out_dh_r >= -19'sd131072 && out_dh_r <= 19'sd131072,
    "Energy change out of range.")
  `XYLM_ASSERT_NEXT(a_fin_word, state_r == S_FIN && (!out_valid_r || !out_stall),
    out_valid_r && state_r == S_IDLE,
    "Finished word not presented on the output.")

endmodule
